>>> src/sha_pkg.sv
// ============================================================================
// sha_pkg
// Shared types and constants for the SHA-256 digest engine.
// ============================================================================
`default_nettype none

package sha_pkg;

  typedef logic [7:0][31:0] sha_state_t;   // index 0 = a / H0

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PADB,
    ST_PADZ,
    ST_LENH,
    ST_LENL,
    ST_OUT
  } sha_st_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RND,
    CS_ADD
  } sha_cst_t;

  typedef struct packed {
    logic init;
    logic start;
  } sha_core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_core_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_WORD = 14;

  localparam sha_state_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

>>> src/sha_buf_mem.sv
// ============================================================================
// sha_buf_mem
// 16 x 32 block buffer, one write port, one registered read port.
// ============================================================================
`default_nettype none

module sha_buf_mem import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [3:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [3:0]  raddr,
  output logic      [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/sha_core.sv
// ============================================================================
// sha_core
// Compression unit: loads 16 words from the block buffer, runs 64 rounds
// one per cycle, then folds the result into the chaining state.
// ============================================================================
`default_nettype none

module sha_core import sha_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sha_core_ctl_t ctl,
  output sha_core_sts_t      sts,
  output logic      [3:0]    rd_addr,
  input  wire logic [31:0]   rd_data,
  output sha_state_t         h_words
);

  sha_cst_t    cst_r, cst_nxt;
  logic [5:0]  cnt_r;
  logic        ld_v_r;
  sha_state_t  h_r, v_r, v_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_new, s0, s1, big0, big1, chs, maj, t1;

  assign h_words = h_r;
  assign rd_addr = cnt_r[3:0];

  always_comb begin
    s0    = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1    = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
            ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    big1  = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
            ^ {v_r[4][24:0], v_r[4][31:25]};
    chs   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + chs + SHA_K[cnt_r] + w_r[0];
    big0  = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
            ^ {v_r[0][21:0], v_r[0][31:22]};
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    v_nxt = {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + big0 + maj};
  end

  always_comb begin
    cst_nxt = cst_r;
    unique case (cst_r)
      CS_IDLE: if (ctl.start) cst_nxt = CS_LOAD;
      CS_LOAD: if (ld_v_r && cnt_r == 6'd0) cst_nxt = CS_RND;
      CS_RND:  if (cnt_r == 6'd63) cst_nxt = CS_ADD;
      CS_ADD:  cst_nxt = CS_IDLE;
      default: cst_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (cst_r != CS_IDLE);
    sts.done = (cst_r == CS_ADD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= CS_IDLE;
      cnt_r  <= '0;
      ld_v_r <= 1'b0;
      h_r    <= SHA_IV;
    end else begin
      cst_r <= cst_nxt;
      unique case (cst_r)
        CS_IDLE: begin
          cnt_r  <= '0;
          ld_v_r <= 1'b0;
          v_r    <= h_r;
          if (ctl.init) h_r <= SHA_IV;
        end
        CS_LOAD: begin
          // cnt wraps 15 -> 0; the last read returns on the wrap cycle
          if (!(ld_v_r && cnt_r == 6'd0)) begin
            ld_v_r <= 1'b1;
            cnt_r  <= {2'b00, cnt_r[3:0] + 4'd1};
          end
          if (ld_v_r) begin
            for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
            w_r[15] <= rd_data;
          end
        end
        CS_RND: begin
          v_r   <= v_nxt;
          cnt_r <= cnt_r + 6'd1;
          for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
          w_r[15] <= w_new;
        end
        CS_ADD: begin
          for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/sha256_message_digest.sv
// ============================================================================
// sha256_message_digest
// Streaming SHA-256: one message byte per input word, digest out as eight
// 32-bit words, most significant first.
// ============================================================================
//  channel | tdata                      | tuser       | tlast
//  in_     | [7:0] data_byte            | byte_valid  | end_of_message
//  out_    | [31:0] digest_word,        | -           | last_word
//          | [34:32] word_index         |             |
//
// One byte per cycle while a block fills. The 64th byte stalls input for
// one block compression: a load of 16 buffer reads, 64 rounds, one add.
// End of message writes padding words, runs one or two compressions (two
// when the length needs an extra block), then streams 8 words; out_tready
// low holds the stream.
// Synchronous active-low reset; chaining state returns to the IV.
`default_nettype none

module sha256_message_digest import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] byte_valid
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast
);

  sha_st_t       st_r, st_nxt, ret_r;
  sha_core_ctl_t ctl;
  sha_core_sts_t sts;
  sha_state_t    h_words;
  logic [5:0]    fill_r;
  logic [63:0]   total_r;
  logic [31:0]   acc_r, acc_ins, pad_word;
  logic [4:0]    wi_r;
  logic          extra_r;
  logic [2:0]    oidx_r;
  logic          out_valid_r, out_last_r;
  logic [39:0]   out_data_r;
  logic          mem_we;
  logic [3:0]    mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [63:0]   bit_len;
  logic          acc_fire, out_load;
  logic [4:0]    wi_tgt;

  sha_buf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sha_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sts     (sts),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .h_words (h_words)
  );

  assign bit_len  = {total_r[60:0], 3'b000};
  assign acc_fire = in_tvalid && in_tready;
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || out_tready);
  assign wi_tgt   = extra_r ? 5'd16 : 5'(LEN_WORD);

  // byte lanes big-endian: position 0 lands in [31:24]
  always_comb begin
    acc_ins  = acc_r;
    pad_word = '0;
    for (int k = 0; k < 4; k++) begin
      if (fill_r[1:0] == 2'(k)) acc_ins[31-8*k -: 8] = in_tdata;
      if (2'(k) < fill_r[1:0])       pad_word[31-8*k -: 8] = acc_r[31-8*k -: 8];
      else if (2'(k) == fill_r[1:0]) pad_word[31-8*k -: 8] = PAD_BYTE;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc_fire) begin
          if (in_tuser[0] && fill_r == 6'd63) st_nxt = ST_COMP;
          else if (in_tlast)                  st_nxt = ST_PADB;
        end
      end
      ST_COMP: if (sts.done) st_nxt = ret_r;
      ST_PADB: st_nxt = ST_PADZ;
      ST_PADZ: begin
        if (wi_r == wi_tgt) st_nxt = extra_r ? ST_COMP : ST_LENH;
      end
      ST_LENH: st_nxt = ST_LENL;
      ST_LENL: st_nxt = ST_COMP;
      ST_OUT:  if (out_load && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = fill_r[5:2];
    mem_wdata = acc_ins;
    ctl.start = 1'b0;
    ctl.init  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        mem_we    = acc_fire && in_tuser[0] && fill_r[1:0] == 2'd3;
        ctl.start = acc_fire && in_tuser[0] && fill_r == 6'd63;
      end
      ST_PADB: begin
        mem_we    = 1'b1;
        mem_wdata = pad_word;
      end
      ST_PADZ: begin
        mem_we    = (wi_r != wi_tgt);
        mem_waddr = wi_r[3:0];
        mem_wdata = '0;
        ctl.start = (wi_r == wi_tgt) && extra_r;
      end
      ST_LENH: begin
        mem_we    = 1'b1;
        mem_waddr = 4'(LEN_WORD);
        mem_wdata = bit_len[63:32];
      end
      ST_LENL: begin
        mem_we    = 1'b1;
        mem_waddr = 4'(LEN_WORD + 1);
        mem_wdata = bit_len[31:0];
        ctl.start = 1'b1;
      end
      ST_OUT:  ctl.init = out_load && oidx_r == 3'd7;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      wi_r        <= '0;
      extra_r     <= 1'b0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (acc_fire && in_tuser[0]) begin
            acc_r   <= acc_ins;
            fill_r  <= fill_r + 6'd1;
            total_r <= total_r + 64'd1;
          end
          ret_r <= in_tlast ? ST_PADB : ST_IDLE;
        end
        ST_PADB: begin
          extra_r <= (fill_r[5:2] >= 4'(LEN_WORD));
          wi_r    <= {1'b0, fill_r[5:2]} + 5'd1;
        end
        ST_PADZ: begin
          if (wi_r != wi_tgt) begin
            wi_r <= wi_r + 5'd1;
          end else if (extra_r) begin
            extra_r <= 1'b0;
            wi_r    <= '0;
            ret_r   <= ST_PADZ;
          end
        end
        ST_LENL: begin
          ret_r  <= ST_OUT;
          oidx_r <= '0;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_r  <= {5'b00000, oidx_r, h_words[oidx_r]};
            out_last_r  <= (oidx_r == 3'd7);
            oidx_r      <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              fill_r  <= '0;
              total_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.busy)
    else $error("input accepted while compression runs");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (st_r == ST_COMP))
    else $error("compression finished outside wait state");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[34:32] == 3'd7))
    else $error("last word without index seven");

  a_out_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> !sts.busy)
    else $error("digest read while compression runs");

endmodule

`default_nettype wire
